@@ rtl/mdnr_pkg.sv @@
// Shared codes, register indexes and the four-state fold table of the net resolver.
`default_nettype none

package mdnr_pkg;

  // Port widths fixed by the word format
  localparam int unsigned FIELD_W = 64;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFGIX_W = 2;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned DIDX_W  = 3;

  // Largest slice that a word can carry
  localparam logic [SIZE_W-1:0] SIZE_MAX = 7'd64;

  // Configuration register indexes
  typedef enum logic [CFGIX_W-1:0] {
    REG_NET_WIDTH    = 2'd0,
    REG_NET_KIND     = 2'd1,
    REG_DRIVER_COUNT = 2'd2
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [6:0] NET_WIDTH_RST    = 7'd8;
  localparam logic [1:0] NET_KIND_RST     = 2'd0;
  localparam logic [3:0] DRIVER_COUNT_RST = 4'd1;

  // Four-state bit code: value plane in bit 0, unknown plane in bit 1
  typedef logic [1:0] code_t;
  localparam code_t C0 = 2'd0;
  localparam code_t C1 = 2'd1;
  localparam code_t CZ = 2'd2;
  localparam code_t CX = 2'd3;

  // Net kinds; the unused code falls back to a plain wire
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_AND   = 2'd1;
  localparam logic [1:0] KIND_OR    = 2'd2;

  // Resolution tables, indexed [kind][driver code][accumulated code]
  localparam code_t FOLD_TABLE [3][4][4] = '{
    '{ '{C0, CX, C0, CX}, '{CX, C1, C1, CX}, '{C0, C1, CZ, CX}, '{CX, CX, CX, CX} },
    '{ '{C0, C0, C0, C0}, '{C0, C1, C1, CX}, '{C0, C1, CZ, CX}, '{C0, CX, CX, CX} },
    '{ '{C0, C1, C0, CX}, '{C1, C1, C1, C1}, '{C0, C1, CZ, CX}, '{CX, C1, CX, CX} }
  };

  // Resolve one driver bit against the accumulated bit
  function automatic code_t fold_code(logic [1:0] kind, code_t drv, code_t acc);
    code_t res;
    case (kind)
      KIND_AND: res = FOLD_TABLE[1][drv][acc];
      KIND_OR:  res = FOLD_TABLE[2][drv][acc];
      default:  res = FOLD_TABLE[0][drv][acc];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mdnr_cell.sv @@
// One driver slot of the resolver chain: holds the slot planes and folds the passing net word.
`default_nettype none

module mdnr_cell import mdnr_pkg::*; #(
  parameter int unsigned Width = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // slot write
  input  wire logic             wr_en_i,
  input  wire logic [Width-1:0] wr_mask_i,
  input  wire logic [Width-1:0] wr_value_i,
  input  wire logic [Width-1:0] wr_unknown_i,
  // fold control
  input  wire logic             active_i,
  input  wire logic [1:0]       kind_i,
  // accumulated net word from the left neighbor
  input  wire logic             tok_i,
  input  wire logic [Width-1:0] acc_value_i,
  input  wire logic [Width-1:0] acc_unknown_i,
  // accumulated net word to the right neighbor
  output logic                  tok_o,
  output logic [Width-1:0]      acc_value_o,
  output logic [Width-1:0]      acc_unknown_o
);

  logic [Width-1:0] slot_value_q, slot_value_d;
  logic [Width-1:0] slot_unknown_q, slot_unknown_d;
  logic [Width-1:0] fold_value, fold_unknown;
  logic [Width-1:0] acc_value_q, acc_value_d;
  logic [Width-1:0] acc_unknown_q, acc_unknown_d;
  logic             tok_q;

  // Merge the driven bits into the slot
  always_comb begin
    slot_value_d   = (slot_value_q & ~wr_mask_i) | (wr_value_i & wr_mask_i);
    slot_unknown_d = (slot_unknown_q & ~wr_mask_i) | (wr_unknown_i & wr_mask_i);
  end

  // Fold every net bit through the resolution table
  always_comb begin
    code_t c;
    c = CZ;
    for (int p = 0; p < Width; p++) begin
      c = fold_code(kind_i, {slot_unknown_q[p], slot_value_q[p]},
                    {acc_unknown_i[p], acc_value_i[p]});
      fold_value[p]   = c[0];
      fold_unknown[p] = c[1];
    end
  end

  // Pass the word untouched when this slot does not take part
  always_comb begin
    acc_value_d   = active_i ? fold_value   : acc_value_i;
    acc_unknown_d = active_i ? fold_unknown : acc_unknown_i;
  end

  // Hold the slot; reset to all z
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_value_q   <= '0;
      slot_unknown_q <= '1;
    end else if (wr_en_i) begin
      slot_value_q   <= slot_value_d;
      slot_unknown_q <= slot_unknown_d;
    end
  end

  // Advance the token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  // Capture the folded word
  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      acc_value_q   <= acc_value_d;
      acc_unknown_q <= acc_unknown_d;
    end
  end

  assign tok_o         = tok_q;
  assign acc_value_o   = acc_value_q;
  assign acc_unknown_o = acc_unknown_q;

endmodule

`default_nettype wire

@@ rtl/multi_driver_net_resolver_top.sv @@
// Four-state multi-driver net resolver: config registers, slot write, cell chain, slice output.
// An accepted start sets launch_q; the fold token then passes each cell's register in turn,
// and result_valid_o and the result word are registered as the token leaves the last cell.
// No new word is taken while one is in flight; start is taken again in the result cycle.
// The fold token walks the cell chain one driver slot per cycle.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset: all slots read as z, net_width 8, net_kind plain, driver_count 1, no word in flight.
`default_nettype none

module multi_driver_net_resolver_top import mdnr_pkg::*; #(
  parameter int unsigned MAX_DRIVERS = 8,
  parameter int unsigned MAX_WIDTH   = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CFGIX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  // command
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [DIDX_W-1:0]   driver_index_i,
  input  wire logic [BASE_W-1:0]   slice_base_i,
  input  wire logic [SIZE_W-1:0]   slice_size_i,
  input  wire logic [FIELD_W-1:0]  value_bits_i,
  input  wire logic [FIELD_W-1:0]  unknown_bits_i,
  // result
  output logic                     result_valid_o,
  output logic [FIELD_W-1:0]       resolved_value_o,
  output logic [FIELD_W-1:0]       resolved_unknown_o
);

  logic [6:0]             net_width_q;
  logic [1:0]             net_kind_q;
  logic [3:0]             driver_count_q;
  logic                   accept;
  logic                   busy_q;
  logic                   launch_q;
  logic                   result_valid_q;
  logic [BASE_W-1:0]      base_q;
  logic [SIZE_W-1:0]      size_q;
  logic [SIZE_W-1:0]      size_c;
  logic [FIELD_W-1:0]     vin_sh, uin_sh;
  logic [MAX_WIDTH-1:0]   wr_mask;
  logic [MAX_DRIVERS-1:0] wr_en;
  logic [MAX_DRIVERS-1:0] active;
  logic [MAX_DRIVERS:0]   tok;
  logic [MAX_WIDTH-1:0]   accv [MAX_DRIVERS+1];
  logic [MAX_WIDTH-1:0]   accu [MAX_DRIVERS+1];
  logic [FIELD_W-1:0]     net_v, net_u;
  logic [2*FIELD_W-1:0]   ext_v, ext_u;
  logic [FIELD_W-1:0]     size_mask;
  logic [FIELD_W-1:0]     res_value_q, res_unknown_q;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_width_q    <= NET_WIDTH_RST;
      net_kind_q     <= NET_KIND_RST;
      driver_count_q <= DRIVER_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_NET_WIDTH:    net_width_q    <= cfg_wdata_i;
        REG_NET_KIND:     net_kind_q     <= cfg_wdata_i[1:0];
        REG_DRIVER_COUNT: driver_count_q <= cfg_wdata_i[3:0];
        default:          ;
      endcase
    end
  end

  assign accept = start && !busy_q;
  assign busy   = busy_q;
  assign size_c = (slice_size_i > SIZE_MAX) ? SIZE_MAX : slice_size_i;

  // Align the driven slice to its net position
  assign vin_sh = value_bits_i << slice_base_i;
  assign uin_sh = unknown_bits_i << slice_base_i;

  // Mark net bits inside the slice and inside the net width
  always_comb begin
    for (int p = 0; p < MAX_WIDTH; p++) begin
      wr_mask[p] = (p >= int'(slice_base_i)) &&
                   (p < int'(slice_base_i) + int'(size_c)) &&
                   ((p == 0) || (int'(net_width_q) > p));
    end
  end

  // Decode the slot write and the slots that take part
  always_comb begin
    for (int k = 0; k < MAX_DRIVERS; k++) begin
      wr_en[k]  = accept && (int'(driver_index_i) == k);
      active[k] = (k == 0) || (int'(driver_count_q) > k);
    end
  end

  // Start the chain from an all-z word
  assign tok[0]  = launch_q;
  assign accv[0] = '0;
  assign accu[0] = '1;

  for (genvar k = 0; k < MAX_DRIVERS; k++) begin : g_cell
    mdnr_cell #(
      .Width (MAX_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .wr_en_i       (wr_en[k]),
      .wr_mask_i     (wr_mask),
      .wr_value_i    (vin_sh[MAX_WIDTH-1:0]),
      .wr_unknown_i  (uin_sh[MAX_WIDTH-1:0]),
      .active_i      (active[k]),
      .kind_i        (net_kind_q),
      .tok_i         (tok[k]),
      .acc_value_i   (accv[k]),
      .acc_unknown_i (accu[k]),
      .tok_o         (tok[k+1]),
      .acc_value_o   (accv[k+1]),
      .acc_unknown_o (accu[k+1])
    );
  end

  // Read net bits beyond the width as x
  for (genvar q = 0; q < FIELD_W; q++) begin : g_net
    if (q < MAX_WIDTH) begin : g_in
      logic in_net;
      assign in_net   = (q == 0) || (int'(net_width_q) > q);
      assign net_v[q] = in_net ? accv[MAX_DRIVERS][q] : 1'b1;
      assign net_u[q] = in_net ? accu[MAX_DRIVERS][q] : 1'b1;
    end else begin : g_out
      assign net_v[q] = 1'b1;
      assign net_u[q] = 1'b1;
    end
  end

  // Extract the requested slice and drop bits above its size
  assign ext_v = {{FIELD_W{1'b1}}, net_v} >> base_q;
  assign ext_u = {{FIELD_W{1'b1}}, net_u} >> base_q;

  always_comb begin
    for (int i = 0; i < FIELD_W; i++) begin
      size_mask[i] = int'(size_q) > i;
    end
  end

  // Track the word in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      launch_q       <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      launch_q       <= accept;
      result_valid_q <= tok[MAX_DRIVERS];
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tok[MAX_DRIVERS]) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold the slice geometry of the word in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_q <= slice_base_i;
      size_q <= size_c;
    end
  end

  // Register the result word
  always_ff @(posedge clk_i) begin
    if (tok[MAX_DRIVERS]) begin
      res_value_q   <= ext_v[FIELD_W-1:0] & size_mask;
      res_unknown_q <= ext_u[FIELD_W-1:0] & size_mask;
    end
  end

  assign result_valid_o     = result_valid_q;
  assign resolved_value_o   = res_value_q;
  assign resolved_unknown_o = res_unknown_q;

`ifndef SYNTH
  // An accepted word keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_q)
    else $error("busy not set after an accepted word");

  // At most one fold token walks the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok))
    else $error("more than one word in the cell chain");

  // A token leaving the chain yields exactly one result
  assert property (@(posedge clk_i) disable iff (!rst_ni) tok[MAX_DRIVERS] |=> result_valid_o)
    else $error("chain output without a result");

  // The result cycle is never a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> !busy_q)
    else $error("result shown while still busy");

  // Tokens only exist while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (tok != '0) |-> busy_q)
    else $error("fold token outside a busy window");
`endif

endmodule

`default_nettype wire
